// File: hdl/hlzd_pkg.sv
// Package: shared types, constants and helpers for the LZ byte-stream decompressor.
`default_nettype none
package hlzd_pkg;

  localparam int HIST_DEPTH = 32768;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int WP_W       = $clog2(HIST_DEPTH + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] END_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_END      = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_CMD     = 3'd0,
    PH_LEN     = 3'd1,
    PH_ARG1    = 3'd2,
    PH_ARG2    = 3'd3,
    PH_LITWAIT = 3'd4,
    PH_EMIT    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    K_LIT  = 3'd0,
    K_REP  = 3'd1,
    K_PAIR = 3'd2,
    K_SEQ  = 3'd3,
    K_FWD  = 3'd4,
    K_INV  = 3'd5,
    K_REV  = 3'd6
  } kind_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_byte;
    logic [15:0] out_count;
  } result_t;

  function automatic kind_t kind_of(input logic [2:0] f);
    kind_t k;
    unique case (f)
      3'd0:    k = K_LIT;
      3'd1:    k = K_REP;
      3'd2:    k = K_PAIR;
      3'd3:    k = K_SEQ;
      3'd5:    k = K_INV;
      3'd6:    k = K_REV;
      default: k = K_FWD;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] bit_rev(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/hlzd_if.sv
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface hlzd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface hlzd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic [15:0] out_count;

  modport source (output valid, output status, output out_byte, output out_count, input ready);
  modport sink (input valid, input status, input out_byte, input out_count, output ready);
endinterface
`default_nettype wire

// File: hdl/hlzd_out_fifo.sv
// Result queue: small register FIFO that decouples the pipeline from the consumer.
`default_nettype none
module hlzd_out_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  hlzd_pkg::result_t                push_data,
  input  wire logic                        pop_ready,
  output logic                             pop_valid,
  output hlzd_pkg::result_t                pop_data,
  output logic [hlzd_pkg::FIFO_CW-1:0]     count
);

  hlzd_pkg::result_t                 slot_r [hlzd_pkg::FIFO_DEPTH];
  logic [hlzd_pkg::FIFO_AW-1:0]      head_r, head_nxt;
  logic [hlzd_pkg::FIFO_AW-1:0]      tail_r, tail_nxt;
  logic [hlzd_pkg::FIFO_CW-1:0]      count_r, count_nxt;
  logic                              pop;

  function automatic logic [hlzd_pkg::FIFO_CW-1:0] FIFO_CW_ONE(input logic b);
    return {{(hlzd_pkg::FIFO_CW-1){1'b0}}, b};
  endfunction

  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[head_r];
  assign pop       = pop_valid && pop_ready;
  assign count     = count_r;

  always_comb begin
    head_nxt  = pop ? head_r + 1'b1 : head_r;
    tail_nxt  = push ? tail_r + 1'b1 : tail_r;
    count_nxt = count_r + FIFO_CW_ONE(push) - FIFO_CW_ONE(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hdl/hal_lz_decompressor_top.sv
// Top level: LZ byte-stream decompressor with history memory and result queue.
//
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | req_type, in_byte
//  out_ch  | out | valid/ready       | status, out_byte, out_count
//
// One item per cycle while in_ch.ready is high; each result passes through the stage 1
// registers and the result queue before it appears on out_ch. Stage 0 updates the parser
// and issues the history read; stage 1 resolves the read (with forwarding from the
// previous write) and writes the produced byte. A four-entry result queue absorbs output
// stalls; input stalls once the queue and stage 1 together hold four items.
// Reset is synchronous, active low; history contents need no clearing.
`default_nettype none
module hal_lz_decompressor_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hlzd_in_if.sink    in_ch,
  hlzd_out_if.source out_ch
);

  // parser state
  hlzd_pkg::phase_t             phase_r, phase_nxt;
  hlzd_pkg::kind_t              kind_r, kind_nxt;
  logic [10:0]                  rem_r, rem_nxt;
  logic [7:0]                   first_r, first_nxt;
  logic [7:0]                   second_r, second_nxt;
  logic                         pair_r, pair_nxt;
  logic [15:0]                  cp_r, cp_nxt;
  logic                         fin_r, fin_nxt;
  logic [hlzd_pkg::WP_W-1:0]    wp_r, wp_nxt;

  // stage 0 results
  hlzd_pkg::status_t            st0;
  logic [7:0]                   val0;
  logic                         wr0, copy0, inv0, done0;
  logic                         zero0, fwd0;
  logic                         in_fire;

  // stage 1
  logic                         s1_valid_r;
  hlzd_pkg::status_t            s1_status_r;
  logic [15:0]                  s1_count_r;
  logic [7:0]                   s1_val_r;
  logic                         s1_copy_r, s1_inv_r, s1_zero_r, s1_fwd_r, s1_wr_r;
  logic [hlzd_pkg::HIST_AW-1:0] s1_addr_r;
  logic [7:0]                   last_wr_r;
  logic [7:0]                   raw1, byte1;

  // history memory
  logic [7:0]                   hist_mem [hlzd_pkg::HIST_DEPTH];
  logic [7:0]                   mem_q_r;

  // result queue
  hlzd_pkg::result_t            res1, res_out;
  logic [hlzd_pkg::FIFO_CW-1:0] fifo_count;
  logic                         fifo_valid;

  assign in_ch.ready = ({1'b0, fifo_count} + {{hlzd_pkg::FIFO_CW{1'b0}}, s1_valid_r})
                       < (hlzd_pkg::FIFO_CW + 1)'(hlzd_pkg::FIFO_DEPTH);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign zero0 = {1'b0, cp_r} >= 17'(wp_r);
  assign fwd0  = s1_wr_r && (cp_r[hlzd_pkg::HIST_AW-1:0] == s1_addr_r);

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    rem_nxt    = rem_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    pair_nxt   = pair_r;
    cp_nxt     = cp_r;
    fin_nxt    = fin_r;
    wp_nxt     = wp_r;
    st0        = hlzd_pkg::ST_OK;
    val0       = 8'd0;
    wr0        = 1'b0;
    copy0      = 1'b0;
    inv0       = 1'b0;
    done0      = 1'b1;
    if (in_fire) begin
      if (!in_ch.req_type) begin
        if (fin_r) begin
          st0 = hlzd_pkg::ST_END;
        end else begin
          unique case (phase_r)
            hlzd_pkg::PH_CMD: begin
              if (in_ch.in_byte == hlzd_pkg::END_BYTE) begin
                fin_nxt = 1'b1;
                st0     = hlzd_pkg::ST_END;
              end else begin
                if (&in_ch.in_byte[7:5]) begin
                  kind_nxt  = hlzd_pkg::kind_of(in_ch.in_byte[4:2]);
                  rem_nxt   = {1'b0, in_ch.in_byte[1:0], 8'd0};
                  phase_nxt = hlzd_pkg::PH_LEN;
                end else begin
                  kind_nxt  = hlzd_pkg::kind_of(in_ch.in_byte[7:5]);
                  rem_nxt   = 11'(in_ch.in_byte[4:0]) + 11'd1;
                  phase_nxt = (kind_nxt == hlzd_pkg::K_LIT) ? hlzd_pkg::PH_LITWAIT
                                                             : hlzd_pkg::PH_ARG1;
                end
                pair_nxt = 1'b0;
              end
            end
            hlzd_pkg::PH_LEN: begin
              rem_nxt   = rem_r + 11'(in_ch.in_byte) + 11'd1;
              phase_nxt = (kind_r == hlzd_pkg::K_LIT) ? hlzd_pkg::PH_LITWAIT
                                                       : hlzd_pkg::PH_ARG1;
            end
            hlzd_pkg::PH_ARG1: begin
              first_nxt = in_ch.in_byte;
              phase_nxt = (kind_r == hlzd_pkg::K_REP || kind_r == hlzd_pkg::K_SEQ)
                          ? hlzd_pkg::PH_EMIT : hlzd_pkg::PH_ARG2;
            end
            hlzd_pkg::PH_ARG2: begin
              if (kind_r == hlzd_pkg::K_PAIR) begin
                second_nxt = in_ch.in_byte;
                pair_nxt   = 1'b0;
              end else begin
                cp_nxt = {first_r, in_ch.in_byte};
              end
              phase_nxt = hlzd_pkg::PH_EMIT;
            end
            hlzd_pkg::PH_LITWAIT: begin
              first_nxt = in_ch.in_byte;
              phase_nxt = hlzd_pkg::PH_EMIT;
            end
            default: begin
              st0 = hlzd_pkg::ST_BUSY;
            end
          endcase
        end
      end else if (phase_r != hlzd_pkg::PH_EMIT) begin
        st0 = fin_r ? hlzd_pkg::ST_END : hlzd_pkg::ST_EMPTY;
      end else if (wp_r >= hlzd_pkg::WP_W'(hlzd_pkg::HIST_DEPTH)) begin
        st0 = hlzd_pkg::ST_OVERFLOW;
      end else begin
        unique case (kind_r)
          hlzd_pkg::K_LIT, hlzd_pkg::K_REP: begin
            val0 = first_r;
          end
          hlzd_pkg::K_PAIR: begin
            val0     = pair_r ? second_r : first_r;
            done0    = pair_r;
            pair_nxt = ~pair_r;
          end
          hlzd_pkg::K_SEQ: begin
            val0      = first_r;
            first_nxt = first_r + 8'd1;
          end
          hlzd_pkg::K_INV: begin
            copy0  = 1'b1;
            inv0   = 1'b1;
            cp_nxt = cp_r + 16'd1;
          end
          hlzd_pkg::K_REV: begin
            copy0  = 1'b1;
            cp_nxt = cp_r - 16'd1;
          end
          default: begin
            copy0  = 1'b1;
            cp_nxt = cp_r + 16'd1;
          end
        endcase
        wr0    = 1'b1;
        wp_nxt = wp_r + 1'b1;
        if (done0) begin
          rem_nxt = rem_r - 11'd1;
          if (rem_nxt == 11'd0) begin
            phase_nxt = hlzd_pkg::PH_CMD;
          end else if (kind_r == hlzd_pkg::K_LIT) begin
            phase_nxt = hlzd_pkg::PH_LITWAIT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= hlzd_pkg::PH_CMD;
      kind_r   <= hlzd_pkg::K_LIT;
      rem_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
      pair_r   <= 1'b0;
      cp_r     <= '0;
      fin_r    <= 1'b0;
      wp_r     <= '0;
    end else begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      rem_r    <= rem_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      pair_r   <= pair_nxt;
      cp_r     <= cp_nxt;
      fin_r    <= fin_nxt;
      wp_r     <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_wr_r    <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      s1_wr_r    <= wr0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= st0;
      s1_count_r  <= 16'(wp_nxt);
      s1_val_r    <= val0;
      s1_copy_r   <= copy0;
      s1_inv_r    <= inv0;
      s1_zero_r   <= zero0;
      s1_fwd_r    <= fwd0;
      s1_addr_r   <= wp_r[hlzd_pkg::HIST_AW-1:0];
    end
    if (s1_wr_r) begin
      last_wr_r <= byte1;
    end
  end

  always_comb begin
    raw1  = s1_zero_r ? 8'd0 : (s1_fwd_r ? last_wr_r : mem_q_r);
    byte1 = s1_copy_r ? (s1_inv_r ? hlzd_pkg::bit_rev(raw1) : raw1) : s1_val_r;
  end

  always_ff @(posedge clk) begin
    if (s1_wr_r) begin
      hist_mem[s1_addr_r] <= byte1;
    end
    if (in_fire) begin
      mem_q_r <= hist_mem[cp_r[hlzd_pkg::HIST_AW-1:0]];
    end
  end

  always_comb begin
    res1.status    = s1_status_r;
    res1.out_byte  = byte1;
    res1.out_count = s1_count_r;
  end

  hlzd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (res1),
    .pop_ready (out_ch.ready),
    .pop_valid (fifo_valid),
    .pop_data  (res_out),
    .count     (fifo_count)
  );

  assign out_ch.valid     = fifo_valid;
  assign out_ch.status    = res_out.status;
  assign out_ch.out_byte  = res_out.out_byte;
  assign out_ch.out_count = res_out.out_count;

  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted item did not reach stage 1");

  a_write_below_wp: assert property (@(posedge clk) disable iff (!rst_n)
    s1_wr_r |-> (17'(s1_addr_r) < 17'(wp_r)))
    else $error("history write at or past write point");

  a_fwd_only_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_fwd_r && s1_copy_r) |-> $past(s1_wr_r))
    else $error("forwarding without a preceding write");

  a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |=> fin_r)
    else $error("end of stream flag cleared");

endmodule
`default_nettype wire
